// File: sv/adf_pkg.sv
// ----------------------------------------------------------------------------
// adf_pkg: shared types and constants for the anisotropic diffusion step
// Pixel and stencil types, csr register indexes, queue sizing and the
// edge-stopping function applied to each neighbor difference.
// ----------------------------------------------------------------------------
package adf_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_WIDTH_W    = 11;
   localparam int CFG_HEIGHT_W   = 13;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int MIN_DIM        = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic [CFG_WIDTH_W-1:0]  image_width;
      logic [CFG_HEIGHT_W-1:0] image_height;
   } cfg_type;

   // the four neighbors and the center of one interior pixel
   typedef struct packed {
      pixel_type above;
      pixel_type right;
      pixel_type below;
      pixel_type left;
      pixel_type centre;
   } stencil_type;

   localparam int STENCIL_W = $bits(stencil_type);

   // floor(100*m / (100 + m*m)) for m in 0..255, as bands of m
   function automatic logic [2:0] phi_mag(input logic [7:0] m);
      logic [2:0] v;
      if (m == 8'd10)
         v = 3'd5;
      else if (m >= 8'd5 && m <= 8'd20)
         v = 3'd4;
      else if (m >= 8'd4 && m <= 8'd30)
         v = 3'd3;
      else if (m >= 8'd3 && m <= 8'd47)
         v = 3'd2;
      else if (m >= 8'd2 && m <= 8'd98)
         v = 3'd1;
      else
         v = 3'd0;
      return v;
   endfunction

   // odd-symmetric phi of (nb - c), range -5..5
   function automatic logic signed [3:0] phi_diff(input pixel_type nb, input pixel_type c);
      logic signed [8:0] d;
      logic [7:0]        m;
      logic [2:0]        v;
      d = $signed({1'b0, nb}) - $signed({1'b0, c});
      m = d[8] ? 8'(-d) : d[7:0];
      v = phi_mag(m);
      return d[8] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

// File: sv/adf_queue.sv
// ----------------------------------------------------------------------------
// adf_queue: short fifo between front and back
// Holds stencils waiting for the arithmetic; exposes its fill count so the
// front can stop taking pixels before it runs out of room.
// ----------------------------------------------------------------------------
module adf_queue #(
   parameter int DATA_W = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic [DATA_W-1:0]                   push_data,
   input  logic                                pop,
   output logic                                head_valid,
   output logic [DATA_W-1:0]                   head_data,
   output logic [adf_pkg::QUEUE_CNT_W-1:0]     count
);
   import adf_pkg::*;

   logic [DATA_W-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign do_push = push && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// File: sv/adf_front.sv
// ----------------------------------------------------------------------------
// adf_front: pixel intake, line store and stencil assembly
// Tracks column and row, reads and rewrites the two line stores, keeps the
// window and pushes a stencil for every interior pixel.
// ----------------------------------------------------------------------------
module adf_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int COL_W      = 10,
   parameter int ROW_W      = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  adf_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  adf_pkg::pixel_type              req_pixel_in,
   input  logic [adf_pkg::QUEUE_CNT_W-1:0] q_count,
   output logic                            push_valid,
   output adf_pkg::stencil_type            push_stencil,
   output logic [COL_W-1:0]                push_col,
   output logic [ROW_W-1:0]                push_row,
   output logic                            push_last
);
   import adf_pkg::*;

   localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HLIM_W = $clog2(MAX_HEIGHT + 1);

   logic [2*PIX_W-1:0] store_ff [MAX_WIDTH];   // {upper line, middle line}

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [31:0]       w_raw, h_raw;
   logic [WLIM_W-1:0] width_lim, col_next;
   logic [HLIM_W-1:0] height_lim, row_next, col_ext_h;
   logic [WLIM_W-1:0] col_ext;
   logic [HLIM_W-1:0] row_ext;
   logic              accept;
   logic              emit;
   logic              last;

   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   pixel_type          s1_px_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [2*PIX_W-1:0] rd_ff;
   pixel_type          rd_up, rd_mid;
   pixel_type          win_left_ff, win_centre_ff;
   pixel_type          above_ff;
   pixel_type          prev_px_ff;
   logic [QUEUE_CNT_W:0] pending;

   // sizes in use, clamped to 3..max
   assign w_raw = 32'(cfg.image_width);
   assign h_raw = 32'(cfg.image_height);
   assign width_lim = WLIM_W'((w_raw < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
                              (w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw);
   assign height_lim = HLIM_W'((h_raw < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
                               (h_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_raw);

   assign col_ext   = WLIM_W'(col_ff);
   assign row_ext   = HLIM_W'(row_ff);
   assign col_ext_h = HLIM_W'(2);
   assign col_next  = col_ext + WLIM_W'(1);
   assign row_next  = row_ext + HLIM_W'(1);

   // space for the beat in flight plus what the queue holds
   assign pending   = (QUEUE_CNT_W + 1)'(q_count) + (QUEUE_CNT_W + 1)'(s1_valid_ff);
   assign req_stall = (pending >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign emit = (row_ext >= col_ext_h) && (row_ext < height_lim) &&
                 (col_ext >= WLIM_W'(2)) && (col_ext < width_lim);
   assign last = (row_next == height_lim) && (col_next == width_lim);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_next >= width_lim) begin
         col_in = '0;
         row_in = (row_next >= height_lim) ? '0 : ROW_W'(row_next);
      end else begin
         col_in = COL_W'(col_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         win_left_ff   <= '0;
         win_centre_ff <= '0;
         above_ff      <= '0;
         prev_px_ff    <= '0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s1_valid_ff) begin
            win_left_ff   <= win_centre_ff;
            win_centre_ff <= rd_mid;
            above_ff      <= rd_up;
            prev_px_ff    <= s1_px_ff;
         end
      end
   end

   // stage one payload and line store read, same address as the write back
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff      <= store_ff[col_ff];
         s1_px_ff   <= req_pixel_in;
         s1_addr_ff <= col_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_col_ff  <= col_ff - COL_W'(1);
         s1_row_ff  <= row_ff - ROW_W'(1);
      end
      if (s1_valid_ff)
         store_ff[s1_addr_ff] <= {rd_mid, s1_px_ff};
   end

   assign rd_up  = rd_ff[2*PIX_W-1:PIX_W];
   assign rd_mid = rd_ff[PIX_W-1:0];

   assign push_valid          = s1_valid_ff && s1_emit_ff;
   assign push_stencil.above  = above_ff;
   assign push_stencil.right  = rd_mid;
   assign push_stencil.below  = prev_px_ff;
   assign push_stencil.left   = win_left_ff;
   assign push_stencil.centre = win_centre_ff;
   assign push_col            = s1_col_ff;
   assign push_row            = s1_row_ff;
   assign push_last           = s1_last_ff;

endmodule

// File: sv/adf_back.sv
// ----------------------------------------------------------------------------
// adf_back: diffusion arithmetic and result register
// Applies phi to the four differences, averages, updates the center pixel
// with saturation and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module adf_back #(
   parameter int COL_W = 10,
   parameter int ROW_W = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  adf_pkg::stencil_type head_stencil,
   input  logic [COL_W-1:0]     head_col,
   input  logic [ROW_W-1:0]     head_row,
   input  logic                 head_last,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output adf_pkg::pixel_type   rsp_pixel_out,
   output logic [COL_W-1:0]     rsp_out_col,
   output logic [ROW_W-1:0]     rsp_out_row,
   output logic                 rsp_frame_last
);
   import adf_pkg::*;

   logic signed [3:0] phi_up, phi_rt, phi_dn, phi_lt;
   logic signed [5:0] sum, sum_adj;
   logic signed [5:0] quo;
   logic signed [9:0] res;
   pixel_type         res_sat;

   logic              valid_ff;
   pixel_type         pixel_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              last_ff;

   assign phi_up = phi_diff(head_stencil.above, head_stencil.centre);
   assign phi_rt = phi_diff(head_stencil.right, head_stencil.centre);
   assign phi_dn = phi_diff(head_stencil.below, head_stencil.centre);
   assign phi_lt = phi_diff(head_stencil.left,  head_stencil.centre);

   assign sum     = 6'(phi_up) + 6'(phi_rt) + 6'(phi_dn) + 6'(phi_lt);
   // divide by four, rounding toward zero
   assign sum_adj = sum + (sum[5] ? 6'sd3 : 6'sd0);
   assign quo     = sum_adj >>> 2;
   assign res     = $signed({2'b00, head_stencil.centre}) + 10'(quo);

   always_comb begin
      if (res[9])
         res_sat = '0;
      else if (res[8])
         res_sat = '1;
      else
         res_sat = res[7:0];
   end

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_ff <= res_sat;
         col_ff   <= head_col;
         row_ff   <= head_row;
         last_ff  <= head_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_out  = pixel_ff;
   assign rsp_out_col    = col_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_frame_last = last_ff;

endmodule

// File: sv/anisotropic_diffusion_step.sv
// ----------------------------------------------------------------------------
// anisotropic_diffusion_step: one 4-neighbor diffusion pass over a stream
// Pixels enter on the req channel in raster order, one per beat. For each
// interior pixel a diffused value leaves on the rsp channel with its column,
// row and an end-of-frame flag; border pixels produce no beat.
// The result for center (r-1, c-1) is formed when pixel (r, c) is taken.
// A result beat follows the pixel causing it through the line store read
// stage, the queue and the result register. Throughput: one pixel per
// cycle while req_stall is low, set by the line store that is read at one
// address and written back at another in the same cycle.
// req_stall rises when the 4-entry queue, counting the beat in the read
// stage, would be full; rsp_stall holds the result register, and the queue
// keeps taking pixels until it fills.
// csr writes (index 0: width, index 1: height) are always ready and are to be
// issued only while no frame is in progress; sizes clamp to 3..max.
// Reset clears counters, window and queue and loads 640 x 480; the line
// stores need no clearing since a frame writes each entry before a result uses it.
// ----------------------------------------------------------------------------
module anisotropic_diffusion_step #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [adf_pkg::PIX_W-1:0]        req_pixel_in,
   // diffused output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [adf_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic [$clog2(MAX_WIDTH)-1:0]     rsp_out_col,
   output logic [$clog2(MAX_HEIGHT)-1:0]    rsp_out_row,
   output logic                             rsp_frame_last,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [adf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [adf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import adf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int Q_W   = STENCIL_W + COL_W + ROW_W + 1;

   cfg_type              cfg_ff;
   logic                 q_push;
   stencil_type          push_stencil;
   logic [COL_W-1:0]     push_col;
   logic [ROW_W-1:0]     push_row;
   logic                 push_last;
   logic [Q_W-1:0]       q_wdata;
   logic [Q_W-1:0]       q_rdata;
   logic                 q_valid;
   logic                 q_pop;
   logic [QUEUE_CNT_W-1:0] q_count;
   stencil_type          head_stencil;
   logic [COL_W-1:0]     head_col;
   logic [ROW_W-1:0]     head_row;
   logic                 head_last;

   // register file, writes always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_RESET;
         cfg_ff.image_height <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_wdata[CFG_WIDTH_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               cfg_ff.image_height <= csr_wdata[CFG_HEIGHT_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;   // unmapped index, write dropped
            end
         endcase
      end
   end

   // front: counters, line stores, window
   adf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_in (req_pixel_in),
      .q_count      (q_count),
      .push_valid   (q_push),
      .push_stencil (push_stencil),
      .push_col     (push_col),
      .push_row     (push_row),
      .push_last    (push_last)
   );

   // stencil queue decouples intake from the result side
   assign q_wdata = {push_stencil, push_col, push_row, push_last};

   adf_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_rdata),
      .count      (q_count)
   );

   assign head_stencil = q_rdata[Q_W-1 -: STENCIL_W];
   assign head_col     = q_rdata[COL_W+ROW_W : ROW_W+1];
   assign head_row     = q_rdata[ROW_W:1];
   assign head_last    = q_rdata[0];

   // back: phi, average, saturate, result register
   adf_back #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_valid),
      .head_stencil   (head_stencil),
      .head_col       (head_col),
      .head_row       (head_row),
      .head_last      (head_last),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last)
   );

   // the intake throttle must keep the queue from ever overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count != QUEUE_CNT_W'(QUEUE_DEPTH)))
      else $error("stencil pushed into a full queue");

   // the back side only pops what is there
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from an empty queue");

   // border pixels never reach the output
   a_no_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_col != '0) && (rsp_out_row != '0))
      else $error("border pixel emitted");

   // a pixel taken while the queue is nearly full must raise the throttle
   a_throttle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && q_count == QUEUE_CNT_W'(QUEUE_DEPTH - 1) && !q_pop)
      |=> req_stall)
      else $error("intake not throttled with the queue near full");

endmodule

// File: tb/anisotropic_diffusion_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anisotropic_diffusion_step_checker: result predictor and scoreboard
// Watches the req, rsp and csr channels. Every pixel taken on req advances
// a private model of the line stores, window and counters. Each diffused
// pixel it predicts is queued and compared field by field with the next
// beat taken on rsp.
// ----------------------------------------------------------------------------
module anisotropic_diffusion_step_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [adf_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [adf_pkg::PIX_W-1:0]       rsp_pixel_out,
   input  logic [COL_W-1:0]                rsp_out_col,
   input  logic [ROW_W-1:0]                rsp_out_row,
   input  logic                            rsp_frame_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [adf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [adf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              failures,
   output int                              pending,
   output int                              checked
);
   import adf_pkg::*;

   typedef struct packed {
      pixel_type         value;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              last;
   } diffused_beat_type;

   pixel_type             upper_line [MAX_WIDTH];
   pixel_type             middle_line [MAX_WIDTH];
   pixel_type             window [3];
   pixel_type             above_held;
   int                    col_pos;
   int                    row_pos;
   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   diffused_beat_type     due_q [$];

   // edge-stopping weight of one neighbor difference
   function automatic int edge_stop(input int d);
      int m;
      int v;
      m = (d < 0) ? -d : d;
      v = (100 * m) / (100 + m * m);
      return (d < 0) ? -v : v;
   endfunction

   function automatic int clamp_dim(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // advance the stencil by one source pixel; returns 1 when a center completes
   function automatic bit diffuse_pixel(input pixel_type px, output diffused_beat_type beat);
      int        w;
      int        h;
      int        idx;
      int        prev;
      int        c;
      int        sum;
      int        r;
      bit        hit;
      pixel_type up_c;
      pixel_type mid_c;
      pixel_type below;
      w     = clamp_dim(int'(width_reg), MIN_DIM, MAX_WIDTH);
      h     = clamp_dim(int'(height_reg), MIN_DIM, MAX_HEIGHT);
      idx   = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
      prev  = (idx > 0) ? idx - 1 : 0;
      up_c  = upper_line[idx];
      mid_c = middle_line[idx];
      below = middle_line[prev];
      beat  = '0;
      hit   = 1'b0;
      window[0] = window[1];
      window[1] = window[2];
      window[2] = mid_c;
      if (row_pos >= 2 && row_pos < h && col_pos >= 2 && col_pos < w) begin
         c   = int'(window[1]);
         sum = edge_stop(int'(above_held) - c) + edge_stop(int'(window[2]) - c)
             + edge_stop(int'(below) - c) + edge_stop(int'(window[0]) - c);
         r   = clamp_dim(c + sum / 4, 0, 255);
         beat.value = pixel_type'(r);
         beat.col   = COL_W'(col_pos - 1);
         beat.row   = ROW_W'(row_pos - 1);
         beat.last  = (row_pos == h - 1) && (col_pos == w - 1);
         hit = 1'b1;
      end
      above_held       = up_c;
      upper_line[idx]  = mid_c;
      middle_line[idx] = px;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return hit;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input logic [31:0] got);
      if (got !== 32'(want)) begin
         failures++;
         $display("%0t rsp %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      diffused_beat_type want;
      diffused_beat_type beat;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         window     = '{default: '0};
         above_held = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         due_q.delete();
         failures   = 0;
         checked    = 0;
         pending    = 0;
      end else begin
         // compare before predicting: a pixel taken now cannot be answered now
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               failures++;
               $display("%0t rsp beat with none due: expected nothing, actual pixel %0d col %0d row %0d",
                        $time, rsp_pixel_out, rsp_out_col, rsp_out_row);
            end else begin
               want = due_q.pop_front();
               checked++;
               check_field("pixel_out", want.value, 32'(rsp_pixel_out));
               check_field("out_col", want.col, 32'(rsp_out_col));
               check_field("out_row", want.row, 32'(rsp_out_row));
               check_field("frame_last", want.last, 32'(rsp_frame_last));
            end
         end
         if (req_valid && !req_stall) begin
            if (diffuse_pixel(req_pixel_in, beat))
               due_q.push_back(beat);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               width_reg = csr_wdata[CFG_WIDTH_W-1:0];
            else if (csr_index == CSR_IMAGE_HEIGHT)
               height_reg = csr_wdata[CFG_HEIGHT_W-1:0];
         end
         pending = due_q.size();
      end
   end

endmodule

// File: tb/anisotropic_diffusion_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anisotropic_diffusion_step_tb: frame-level regression of the diffusion step
// Streams whole frames of grayscale pixels through the block under a range of
// image sizes, from the 3 x 3 minimum and clamped register values up to rows
// of several dozen pixels, with random gaps on the pixel side and random
// back-pressure on the result side. A checker module predicts every diffused
// pixel and scores the result beats; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module anisotropic_diffusion_step_tb;
   import adf_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int ROW_W         = $clog2(MAX_HEIGHT);
   localparam int TARGET_PIXELS = 650;
   localparam int DRAIN_CYCLES  = 20;

   // hand-picked 5 x 5 probe: full-scale steps, a difference of exactly ten
   // (strongest weight) and a negative sum that truncates toward zero
   localparam logic [25*8-1:0] PROBE_IMAGE = {
      8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
      8'd255, 8'd100, 8'd110, 8'd90,  8'd10,
      8'd10,  8'd120, 8'd128, 8'd255, 8'd3,
      8'd0,   8'd118, 8'd138, 8'd0,   8'd200,
      8'd255, 8'd0,   8'd128, 8'd10,  8'd255
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic [COL_W-1:0]       rsp_out_col;
   logic [ROW_W-1:0]       rsp_out_row;
   logic                   rsp_frame_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int failures;
   int pending;
   int checked;

   // run bookkeeping for the summary
   int pixels_sent;
   int frames_sent;
   int settings_used;

   // quiet stretches: while set, a side takes no idle cycles at all
   bit req_quiet;
   bit rsp_quiet;

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   anisotropic_diffusion_step #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   anisotropic_diffusion_step_checker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .pending        (pending),
      .checked        (checked)
   );

   // idle cycles ahead of one beat, 0..13, with occasional quiet stretches
   task automatic draw_gap(inout bit quiet, output int gap);
      if ($urandom_range(0, 39) == 0)
         quiet = !quiet;
      gap = quiet ? 0 : int'($urandom_range(0, 13));
   endtask

   // one pixel beat; called and returns at a falling edge
   task automatic push_pixel(input pixel_type p);
      int gap;
      draw_gap(req_quiet, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // valid stays high across back-to-back beats, only the payload moves
      req_valid    <= 1'b1;
      req_pixel_in <= p;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      // valid is seen low before a following write raises it again
      @(negedge clock);
   endtask

   // wait for every due result, then let the pipeline run dry
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // one raster frame; content is mostly smooth with local noise so the
   // neighbor differences land where the weights are nonzero
   task automatic send_frame(input int w, input int h);
      int        style;
      int        level;
      int        v;
      pixel_type p;
      style = $urandom_range(0, 9);
      level = $urandom_range(0, 255);
      for (int k = 0; k < w * h; k++) begin
         if (style == 0 || $urandom_range(0, 19) == 0) begin
            p = pixel_type'($urandom_range(0, 255));
         end else if (style == 1) begin
            p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else begin
            level = level + int'($urandom_range(0, 6)) - 3;
            level = (level < 0) ? 0 : ((level > 255) ? 255 : level);
            v = level + int'($urandom_range(0, 24)) - 12;
            p = pixel_type'((v < 0) ? 0 : ((v > 255) ? 255 : v));
         end
         push_pixel(p);
      end
      pixels_sent += w * h;
      frames_sent++;
   endtask

   // new size between frames, then a run of frames at that size
   task automatic run_setting(input logic [CSR_DATA_W-1:0] width_word,
                              input logic [CSR_DATA_W-1:0] height_word,
                              input int frames);
      int w;
      int h;
      settle();
      write_reg(CSR_IMAGE_WIDTH, width_word);
      write_reg(CSR_IMAGE_HEIGHT, height_word);
      settings_used++;
      // the block clamps the register fields to 3..max
      w = int'(width_word[CFG_WIDTH_W-1:0]);
      h = int'(height_word[CFG_HEIGHT_W-1:0]);
      w = (w < MIN_DIM) ? MIN_DIM : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      h = (h < MIN_DIM) ? MIN_DIM : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
      repeat (frames) send_frame(w, h);
   endtask

   // result side: random back-pressure ahead of every beat
   initial begin
      int gap;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         draw_gap(rsp_quiet, gap);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // pixel side and verdict
   initial begin
      int w;
      int h;
      req_valid     = 1'b0;
      req_pixel_in  = '0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_IMAGE_WIDTH;
      csr_wdata     = '0;
      pixels_sent   = 0;
      frames_sent   = 0;
      settings_used = 0;
      reset         = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed probe frame
      settle();
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(5));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(5));
      settings_used++;
      for (int k = 0; k < 25; k++)
         push_pixel(PROBE_IMAGE[(24 - k) * 8 +: 8]);
      pixels_sent += 25;
      frames_sent++;

      // below-minimum sizes clamp to 3, high width bits are ignored
      run_setting(CSR_DATA_W'(0), CSR_DATA_W'(0), 2);
      run_setting(CSR_DATA_W'(2), CSR_DATA_W'(1), 1);
      run_setting({2'b11, 11'd6}, CSR_DATA_W'(4), 1);

      // random sizes, mostly small, one to three frames each
      while (pixels_sent < TARGET_PIXELS) begin
         if ($urandom_range(0, 29) == 0)
            w = $urandom_range(0, 2);
         else if ($urandom_range(0, 4) == 0)
            w = $urandom_range(17, 63);
         else
            w = $urandom_range(3, 16);
         h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         run_setting({2'($urandom_range(0, 3)), 11'(w)}, CSR_DATA_W'(h),
                     $urandom_range(1, 3));
      end

      // drain
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("streamed %0d pixels in %0d frames over %0d image sizes",
               pixels_sent, frames_sent, settings_used);
      $display("scored %0d diffused pixels, %0d mismatches", checked, failures);
      if (failures == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
